// ===== src/cvl_pkg.sv =====
// Package for the compacting value list: capacity default, operation and
// status codes, transfer payload structs and the cell control struct.
// No dependencies.
package cvl_pkg;

    localparam int CAPACITY = 256;

    localparam logic [1:0] MODE_APPEND   = 2'd0;
    localparam logic [1:0] MODE_REMOVE   = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;
    localparam logic [1:0] MODE_CONTAINS = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
        logic [7:0]         index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic [1:0]         status;
        logic [8:0]         count;
    } t_out_item;

    typedef struct packed {
        logic        shift;
        logic        wr;
        logic [31:0] wdata;
    } t_cell_ctl;

endpackage

// ===== src/cvl_cell.sv =====
// One storage cell of the list chain: holds one entry, takes its right
// neighbor on shift, or the broadcast write data when selected. Uses cvl_pkg.
module cvl_cell
    import cvl_pkg::*;
#(
    parameter int CAPACITY = cvl_pkg::CAPACITY,
    parameter int IDX      = 0,
    localparam int IW      = $clog2(CAPACITY)
) (
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  logic [IW-1:0]   i_wsel,
    input  logic [31:0]     i_nbr,
    output logic [31:0]     o_data
);

    logic [31:0] r_data;
    logic [31:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.wr && (i_wsel == IW'(IDX))) begin
            n_data = i_ctl.wdata;
        end else if (i_ctl.shift) begin
            n_data = i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== src/cvl_chain.sv =====
// Ring of CAPACITY cvl_cell instances; on shift every cell not selected for a write
// takes its right neighbor and the last cell takes the head. Uses cvl_pkg, cvl_cell.
module cvl_chain
    import cvl_pkg::*;
#(
    parameter int CAPACITY = cvl_pkg::CAPACITY,
    localparam int IW      = $clog2(CAPACITY)
) (
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  logic [IW-1:0]   i_wsel,
    output logic [31:0]     o_head
);

    logic [31:0] w_data [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        cvl_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_wsel (i_wsel),
            .i_nbr  (w_data[(g + 1) % CAPACITY]),
            .o_data (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

// ===== src/compacting_value_list_top.sv =====
// Top level of the compacting value list: request/result control around
// the cvl_chain ring of cells. Uses cvl_pkg, cvl_chain.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_data carries one request
//   (mode, value, index); output channel o_out_valid / i_out_stall /
//   o_out_data carries exactly one result per request.
//   Append writes the cell at the current count directly and goes straight to
//   the done state without a pass over the ring.
//   Remove, read and contains rotate the whole ring once, one shift per cycle,
//   before the result is formed. Remove compacts during the same pass by
//   writing each kept entry back to the cell that now holds its new position.
//   One request is in work at a time; o_in_stall is high while it runs.
//   A finished result sits in the output register; a new request is taken
//   while it waits, and a later result waits in the control until the
//   output register is free.
//   Reset clears the count and the control; cell contents are not reset and
//   are only read below the count.
module compacting_value_list_top
    import cvl_pkg::*;
#(
    parameter int CAPACITY = cvl_pkg::CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [IW-1:0]      r_step, n_step;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_kept, n_kept;
    logic [IW-1:0]      r_wc, n_wc;
    logic [1:0]         r_mode, n_mode;
    logic [31:0]        r_value, n_value;
    logic [7:0]         r_index, n_index;
    logic [31:0]        r_rd, n_rd;
    logic               r_found, n_found;
    logic [1:0]         r_status, n_status;
    t_out_item          r_out, n_out;
    logic               r_ovalid, n_ovalid;

    t_cell_ctl          w_ctl;
    logic [IW-1:0]      w_wsel;
    logic [31:0]        w_head;
    logic               w_accept;
    logic               w_in_range;
    logic               w_out_free;

    cvl_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_wsel (w_wsel),
        .o_head (w_head)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_in_range  = (CW'(r_step) < r_count);
    assign w_out_free  = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_count  = r_count;
        n_kept   = r_kept;
        n_wc     = r_wc;
        n_mode   = r_mode;
        n_value  = r_value;
        n_index  = r_index;
        n_rd     = r_rd;
        n_found  = r_found;
        n_status = r_status;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        w_ctl    = '{shift: 1'b0, wr: 1'b0, wdata: w_head};
        w_wsel   = r_wc;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode   = i_in_data.mode;
                    n_value  = i_in_data.value;
                    n_index  = i_in_data.index;
                    n_rd     = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_step   = '0;
                    n_kept   = '0;
                    n_wc     = IW'(CAPACITY - 1);
                    n_state  = S_RUN;
                    unique case (i_in_data.mode)
                        MODE_APPEND: begin
                            n_state = S_DONE;
                            if (r_count < CW'(CAPACITY)) begin
                                w_ctl.wr    = 1'b1;
                                w_ctl.wdata = i_in_data.value;
                                w_wsel      = r_count[IW-1:0];
                                n_count     = r_count + 1'b1;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        MODE_READ: begin
                            if (!(XW'(i_in_data.index) < XW'(r_count))) begin
                                n_rd     = '1;
                                n_status = ST_RANGE;
                            end
                        end
                        MODE_REMOVE, MODE_CONTAINS: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                w_ctl.shift = 1'b1;
                unique case (r_mode)
                    MODE_REMOVE: begin
                        if (w_in_range) begin
                            if (w_head != r_value) begin
                                w_ctl.wr = 1'b1;
                                n_kept   = r_kept + 1'b1;
                            end else begin
                                n_wc = (r_wc == '0) ? IW'(CAPACITY - 1) : r_wc - 1'b1;
                            end
                        end
                    end
                    MODE_READ: begin
                        if (w_in_range && (XW'(r_step) == XW'(r_index))) begin
                            n_rd = w_head;
                        end
                    end
                    MODE_CONTAINS: begin
                        if (w_in_range && (w_head == r_value)) begin
                            n_found = 1'b1;
                        end
                    end
                    MODE_APPEND: begin
                    end
                    default: begin
                    end
                endcase
                if (r_step == IW'(CAPACITY - 1)) begin
                    n_step  = '0;
                    n_state = S_DONE;
                    if (r_mode == MODE_REMOVE) begin
                        n_count = n_kept;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out.read_value = r_rd;
                    n_out.found      = r_found;
                    n_out.status     = r_status;
                    n_out.count      = 9'(r_count);
                    n_ovalid         = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_count  <= '0;
            r_kept   <= '0;
            r_wc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_count  <= n_count;
            r_kept   <= n_kept;
            r_wc     <= n_wc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_value  <= n_value;
        r_index  <= n_index;
        r_rd     <= n_rd;
        r_found  <= n_found;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
